// File: rtl/core/mubt_pkg.sv
// Motor usage bin tracker: shared types, codes and constants.
// Used by every module of the core; depends on nothing.
package mubt_pkg;

  localparam int PULSE_W    = 12;
  localparam int RPM_W      = 16;
  localparam int TIME_W     = 48;
  localparam int USAGE_W    = 40;
  localparam int AVG_W      = 24;
  localparam int TOTAL_W    = 46;
  localparam int TIMEOUT_W  = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // serial multiply and divide run over the magnitude of the average step
  localparam int MAG_W  = AVG_W;
  localparam int MPROD_W = MAG_W + USAGE_W;
  localparam int CNT_W  = $clog2(MAG_W);

  localparam int BIN_WIDTH_DEF = 50;
  localparam int NUM_BINS_DEF  = 64;

  localparam logic [PULSE_W-1:0]   NEUTRAL_RESET = 12'd1500;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd10000000;
  localparam logic [USAGE_W-1:0]   USAGE_MAX     = {USAGE_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    ACT_RPM    = 2'd0,
    ACT_PULSE  = 2'd1,
    ACT_REPORT = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_SUM, S_SAT, S_DEC, S_MUL, S_DIVI, S_DIV, S_UPD, S_FIN,
    S_WALK, S_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_bin;
    logic sum;
    logic sat;
    logic wr_plain;
    logic mul_start;
    logic mul_step;
    logic div_init;
    logic div_step;
    logic wr_upd;
    logic fin;
    logic walk_start;
    logic walk_emit;
  } cmd_t;

  typedef struct packed {
    logic charge_ok;
    logic first;
    logic charged_zero;
    logic cnt_last;
    logic walk_last;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/core/mubt_ctrl.sv
// Motor usage bin tracker: sequencing state machine.
// Drives datapath commands from its status; uses mubt_pkg.
module mubt_ctrl import mubt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] action,
  output logic       in_ready,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.accept = 1'b1;
          unique case (action)
            ACT_PULSE:  state_next = S_CHK;
            ACT_REPORT: state_next = S_WALK;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_CHK: begin
        if (stat.charge_ok) begin
          cmd.rd_bin = 1'b1;
          state_next = S_SUM;
        end else begin
          state_next = S_FIN;
        end
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_SAT;
      end
      S_SAT: begin
        cmd.sat    = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        if (stat.first || stat.charged_zero) begin
          cmd.wr_plain = 1'b1;
          state_next   = S_FIN;
        end else begin
          cmd.mul_start = 1'b1;
          state_next    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.cnt_last) state_next = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.cnt_last) state_next = S_UPD;
      end
      S_UPD: begin
        cmd.wr_upd = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        cmd.walk_start = 1'b1;
        state_next     = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.walk_emit = 1'b1;
          if (stat.walk_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: rtl/core/mubt_datapath.sv
// Motor usage bin tracker: registers, bin tables, serial multiply/divide
// and output register. Commanded by mubt_ctrl; uses mubt_pkg.
module mubt_datapath import mubt_pkg::*; #(
  parameter int BIN_WIDTH = BIN_WIDTH_DEF,
  parameter int NUM_BINS  = NUM_BINS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  output stat_t                        stat,
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic [1:0]                   action,
  input  logic signed [RPM_W-1:0]      rpm_in,
  input  logic [PULSE_W-1:0]           pulse_micros,
  input  logic [TIME_W-1:0]            now_us,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         kind,
  output logic signed [RPM_W-1:0]      signed_rpm,
  output logic [PULSE_W-1:0]           bin_start,
  output logic                         bin_used,
  output logic [USAGE_W-1:0]           usage_us,
  output logic signed [AVG_W-1:0]      avg_rpm_q8,
  output logic [TOTAL_W-1:0]           total_running_us,
  output logic                         rpm_stale,
  output logic                         last
);

  localparam int ADDR_W   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int DIV_SH   = PULSE_W + $clog2(BIN_WIDTH);
  localparam int RECIP    = ((1 << DIV_SH) + BIN_WIDTH - 1) / BIN_WIDTH;
  localparam int RECIP_W  = PULSE_W + 2;
  localparam int BPROD_W  = PULSE_W + RECIP_W;
  localparam logic [PULSE_W-1:0] BIN_STEP   = PULSE_W'(BIN_WIDTH);
  localparam logic [PULSE_W-1:0] NUM_BINS_P = PULSE_W'(NUM_BINS);
  localparam logic [ADDR_W-1:0]  LAST_BIN   = ADDR_W'(NUM_BINS - 1);

  // exact floor(p / BIN_WIDTH) over all 12-bit p by reciprocal multiply
  function automatic logic [PULSE_W-1:0] bin_of(input logic [PULSE_W-1:0] p);
    logic [BPROD_W-1:0] prod;
    prod = BPROD_W'(p) * BPROD_W'(RECIP);
    return PULSE_W'(prod >> DIV_SH);
  endfunction

  logic [PULSE_W-1:0]   neutral;
  logic [TIMEOUT_W-1:0] timeout;

  logic signed [RPM_W-1:0] latest_rpm;
  logic [TIME_W-1:0]       rpm_seen_time;
  logic [PULSE_W-1:0]      prev_pulse;
  logic                    prev_valid;
  logic [TIME_W-1:0]       prev_time;

  logic [PULSE_W-1:0]      in_pulse;
  logic [TIME_W-1:0]       in_now;
  logic [RPM_W-1:0]        srpm;
  logic                    stale;

  logic [USAGE_W-1:0] usage_mem [NUM_BINS];
  logic [AVG_W-1:0]   avg_mem   [NUM_BINS];
  logic [NUM_BINS-1:0] occ;
  logic [USAGE_W-1:0] rd_usage;
  logic [AVG_W-1:0]   rd_avg;
  logic               rd_occ;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [AVG_W-1:0]   wr_avg;

  logic [ADDR_W-1:0]  idx_reg;
  logic [TIME_W-1:0]  dur;
  logic [TIME_W:0]    sum;
  logic [USAGE_W-1:0] old_usage;
  logic [AVG_W-1:0]   avg_old;
  logic               occ_reg;
  logic [USAGE_W-1:0] nu;
  logic [USAGE_W-1:0] charged;
  logic               neg;
  logic [MAG_W-1:0]   mag_sh;
  logic [MPROD_W-1:0] prod;
  logic [USAGE_W-1:0] rem;
  logic [MAG_W-1:0]   quo;
  logic [CNT_W-1:0]   cnt;

  logic [ADDR_W-1:0]  k;
  logic [PULSE_W-1:0] bstart;
  logic [TOTAL_W-1:0] total;

  logic [PULSE_W-1:0] idx_c;
  logic [PULSE_W-1:0] nbin_c;
  logic [RPM_W-1:0]   rpm_mag;
  logic [RPM_W-1:0]   srpm_c;
  logic [TIME_W-1:0]  age;
  logic               stale_c;
  logic [USAGE_W-1:0] old_c;
  logic [AVG_W-1:0]   target;
  logic [AVG_W:0]     delta_c;
  logic [AVG_W-1:0]   avg_upd;
  logic [USAGE_W:0]   trial;
  logic               trial_ge;
  logic [USAGE_W-1:0] usage_cur;
  logic [TOTAL_W-1:0] total_next;
  logic               walk_last;

  assign idx_c   = bin_of(prev_pulse);
  assign nbin_c  = bin_of(neutral);
  assign rpm_mag = latest_rpm[RPM_W-1] ?
                   ((latest_rpm == {1'b1, {(RPM_W-1){1'b0}}}) ? {1'b0, {(RPM_W-1){1'b1}}}
                                                            : RPM_W'(-latest_rpm))
                   : RPM_W'(latest_rpm);
  assign srpm_c  = (pulse_micros > neutral) ? rpm_mag :
                   (pulse_micros < neutral) ? RPM_W'(-rpm_mag) : '0;
  assign age     = now_us - rpm_seen_time;
  assign stale_c = (now_us >= rpm_seen_time) && (age > TIME_W'(timeout));
  assign old_c   = rd_occ ? rd_usage : '0;
  assign target  = {latest_rpm, 8'h00};
  assign delta_c = {target[AVG_W-1], target} - {avg_old[AVG_W-1], avg_old};
  assign avg_upd = neg ? (avg_old - quo) : (avg_old + quo);
  assign trial   = {rem, quo[MAG_W-1]};
  assign trial_ge = trial >= {1'b0, nu};
  assign usage_cur  = rd_occ ? rd_usage : '0;
  assign walk_last  = k == LAST_BIN;
  assign total_next = total + ((PULSE_W'(k) != nbin_c) ? TOTAL_W'(usage_cur) : '0);

  assign stat.charge_ok    = prev_valid && (idx_c < NUM_BINS_P);
  assign stat.first        = !occ_reg;
  assign stat.charged_zero = nu == old_usage;
  assign stat.cnt_last     = cnt == CNT_W'(MAG_W - 1);
  assign stat.walk_last    = walk_last;
  assign stat.out_free     = !out_valid || out_ready;

  // configuration and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      neutral       <= NEUTRAL_RESET;
      timeout       <= TIMEOUT_RESET;
      latest_rpm    <= '0;
      rpm_seen_time <= '0;
      prev_pulse    <= '0;
      prev_valid    <= 1'b0;
      prev_time     <= '0;
      occ           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_NEUTRAL: neutral <= cfg_data[PULSE_W-1:0];
          CFG_TIMEOUT: timeout <= cfg_data[TIMEOUT_W-1:0];
        endcase
      end
      if (cmd.accept && (action == ACT_RPM)) begin
        latest_rpm    <= rpm_in;
        rpm_seen_time <= now_us;
      end
      if (cmd.fin) begin
        prev_pulse <= in_pulse;
        prev_time  <= in_now;
        prev_valid <= 1'b1;
      end
      if (wr_en) occ[idx_reg] <= 1'b1;
      if (cmd.fin || cmd.walk_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // bin tables: one write port, one registered read port
  assign rd_en   = cmd.rd_bin || cmd.walk_start || (cmd.walk_emit && !walk_last);
  assign rd_addr = cmd.rd_bin ? idx_c[ADDR_W-1:0] : (cmd.walk_start ? '0 : k + 1'b1);
  assign wr_en   = cmd.wr_plain || cmd.wr_upd;
  assign wr_avg  = cmd.wr_upd ? avg_upd : (occ_reg ? avg_old : target);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      usage_mem[idx_reg] <= nu;
      avg_mem[idx_reg]   <= wr_avg;
    end
    if (rd_en) begin
      rd_usage <= usage_mem[rd_addr];
      rd_avg   <= avg_mem[rd_addr];
      rd_occ   <= occ[rd_addr];
    end
  end

  // charging arithmetic and report walk
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_pulse <= pulse_micros;
      in_now   <= now_us;
      srpm     <= srpm_c;
      stale    <= stale_c;
    end
    if (cmd.rd_bin) begin
      idx_reg <= idx_c[ADDR_W-1:0];
      dur     <= (in_now >= prev_time) ? (in_now - prev_time) : '0;
    end
    if (cmd.sum) begin
      sum       <= (TIME_W+1)'(old_c) + (TIME_W+1)'(dur);
      old_usage <= old_c;
      avg_old   <= rd_occ ? rd_avg : '0;
      occ_reg   <= rd_occ;
    end
    if (cmd.sat) begin
      nu <= (sum > (TIME_W+1)'(USAGE_MAX)) ? USAGE_MAX : sum[USAGE_W-1:0];
    end
    if (cmd.mul_start) begin
      charged <= nu - old_usage;
      neg     <= delta_c[AVG_W];
      mag_sh  <= delta_c[AVG_W] ? MAG_W'((AVG_W+1)'(0) - delta_c) : delta_c[MAG_W-1:0];
      prod    <= '0;
      cnt     <= '0;
    end
    if (cmd.mul_step) begin
      prod   <= (prod << 1) + (mag_sh[MAG_W-1] ? MPROD_W'(charged) : '0);
      mag_sh <= mag_sh << 1;
      cnt    <= cnt + 1'b1;
    end
    if (cmd.div_init) begin
      rem <= prod[MPROD_W-1:MAG_W];
      quo <= prod[MAG_W-1:0];
      cnt <= '0;
    end
    if (cmd.div_step) begin
      rem <= trial_ge ? USAGE_W'(trial - {1'b0, nu}) : trial[USAGE_W-1:0];
      quo <= {quo[MAG_W-2:0], trial_ge};
      cnt <= cnt + 1'b1;
    end
    if (cmd.walk_start) begin
      k      <= '0;
      bstart <= '0;
      total  <= '0;
    end
    if (cmd.walk_emit) begin
      k      <= k + 1'b1;
      bstart <= bstart + BIN_STEP;
      total  <= total_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      kind             <= 1'b0;
      signed_rpm       <= srpm;
      bin_start        <= '0;
      bin_used         <= 1'b0;
      usage_us         <= '0;
      avg_rpm_q8       <= '0;
      total_running_us <= '0;
      rpm_stale        <= 1'b0;
      last             <= 1'b1;
    end else if (cmd.walk_emit) begin
      kind             <= 1'b1;
      signed_rpm       <= '0;
      bin_start        <= bstart;
      bin_used         <= rd_occ;
      usage_us         <= usage_cur;
      avg_rpm_q8       <= rd_occ ? rd_avg : '0;
      total_running_us <= walk_last ? total_next : '0;
      rpm_stale        <= stale;
      last             <= walk_last;
    end
  end

endmodule

// File: rtl/core/motor_usage_bin_tracker_core.sv
// Motor usage bin tracker: top level.
// Joins mubt_ctrl and mubt_datapath; uses mubt_pkg.
//
// Input channel (in_valid/in_ready) carries one transaction per report:
// action 0 latches rpm_in and now_us, action 1 charges the elapsed time to
// the bin of the previous pulse width and answers with one direction status
// result, action 2 walks every bin and answers with NUM_BINS usage records,
// the last one carrying the total over non-neutral bins. Action 3 is dropped.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data),
// index 0 neutral pulse width, index 1 rpm timeout; write only while idle.
// One transaction is worked at a time; in_ready is high only when idle.
// A pulse report with nothing to charge skips the arithmetic; a plain charge
// only sums, saturates and writes; when the average moves it runs a 24-step
// serial multiply then a 24-step serial divide. A usage report gives one record
// a cycle from the single bin table read port while the output is not stalled.
// Results go through a one-deep output register (out_valid/out_ready); a
// stalled receiver holds it and the walk or status waits behind it.
// Reset (rst, synchronous) restores configuration defaults, clears the control
// state and marks every bin uncharged at once; no clearing pass is needed.
module motor_usage_bin_tracker_core import mubt_pkg::*; #(
  parameter int BIN_WIDTH = BIN_WIDTH_DEF,
  parameter int NUM_BINS  = NUM_BINS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              action,
  input  logic signed [RPM_W-1:0] rpm_in,
  input  logic [PULSE_W-1:0]      pulse_micros,
  input  logic [TIME_W-1:0]       now_us,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    kind,
  output logic signed [RPM_W-1:0] signed_rpm,
  output logic [PULSE_W-1:0]      bin_start,
  output logic                    bin_used,
  output logic [USAGE_W-1:0]      usage_us,
  output logic signed [AVG_W-1:0] avg_rpm_q8,
  output logic [TOTAL_W-1:0]      total_running_us,
  output logic                    rpm_stale,
  output logic                    last
);

  cmd_t  cmd;
  stat_t stat;

  mubt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mubt_datapath #(
    .BIN_WIDTH (BIN_WIDTH),
    .NUM_BINS  (NUM_BINS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .action           (action),
    .rpm_in           (rpm_in),
    .pulse_micros     (pulse_micros),
    .now_us           (now_us),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .signed_rpm       (signed_rpm),
    .bin_start        (bin_start),
    .bin_used         (bin_used),
    .usage_us         (usage_us),
    .avg_rpm_q8       (avg_rpm_q8),
    .total_running_us (total_running_us),
    .rpm_stale        (rpm_stale),
    .last             (last)
  );

endmodule

// File: rtl/core/mubt_checker.sv
// Motor usage bin tracker: port-level assertions and their bind.
// Watches motor_usage_bin_tracker_core ports only; uses mubt_pkg.
module mubt_checker import mubt_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    cfg_wr_en,
  input logic [CFG_IDX_W-1:0]    cfg_index,
  input logic [CFG_DATA_W-1:0]   cfg_data,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [1:0]              action,
  input logic signed [RPM_W-1:0] rpm_in,
  input logic [PULSE_W-1:0]      pulse_micros,
  input logic [TIME_W-1:0]       now_us,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    kind,
  input logic signed [RPM_W-1:0] signed_rpm,
  input logic [PULSE_W-1:0]      bin_start,
  input logic                    bin_used,
  input logic [USAGE_W-1:0]      usage_us,
  input logic signed [AVG_W-1:0] avg_rpm_q8,
  input logic [TOTAL_W-1:0]      total_running_us,
  input logic                    rpm_stale,
  input logic                    last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(signed_rpm) &&
      $stable(bin_start) && $stable(bin_used) && $stable(usage_us) &&
      $stable(avg_rpm_q8) && $stable(total_running_us) && $stable(rpm_stale) &&
      $stable(last))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input taken during a usage walk");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> last && !bin_used && (usage_us == '0))
    else $error("malformed direction status");

  a_total_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> total_running_us == '0)
    else $error("total shown before final record");

endmodule

bind motor_usage_bin_tracker_core mubt_checker u_mubt_checker (.*);

// File: sim/tb.sv
// Testbench for motor_usage_bin_tracker_core: drives rpm, pulse, usage-report
// and unused-action transactions with random idling on both channels and
// checks every result. Depends on mubt_pkg and the core RTL.
module tb;
  import mubt_pkg::*;

  localparam int BWIDTH = BIN_WIDTH_DEF;
  localparam int NBINS  = NUM_BINS_DEF;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_RECORD = 1'b1;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic                    kind;
    logic signed [RPM_W-1:0] signed_rpm;
    logic [PULSE_W-1:0]      bin_start;
    logic                    bin_used;
    logic [USAGE_W-1:0]      usage_us;
    logic signed [AVG_W-1:0] avg_rpm_q8;
    logic [TOTAL_W-1:0]      total_running_us;
    logic                    rpm_stale;
    logic                    last;
  } usage_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = ACT_RPM;
  logic signed [RPM_W-1:0] rpm_in = '0;
  logic [PULSE_W-1:0] pulse_micros = '0;
  logic [TIME_W-1:0] now_us = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic kind;
  logic signed [RPM_W-1:0] signed_rpm;
  logic [PULSE_W-1:0] bin_start;
  logic bin_used;
  logic [USAGE_W-1:0] usage_us;
  logic signed [AVG_W-1:0] avg_rpm_q8;
  logic [TOTAL_W-1:0] total_running_us;
  logic rpm_stale;
  logic last;

  // expected-behaviour state
  bit [PULSE_W-1:0] neutral_cfg = NEUTRAL_RESET;
  bit [TIMEOUT_W-1:0] timeout_cfg = TIMEOUT_RESET;
  bit signed [RPM_W-1:0] rpm_latched;
  bit [TIME_W-1:0] rpm_time;
  bit [PULSE_W-1:0] last_pulse;
  bit last_pulse_ok;
  bit [TIME_W-1:0] last_pulse_time;
  bit [USAGE_W-1:0] usage_tab [NBINS];
  bit signed [AVG_W-1:0] avg_tab [NBINS];
  bit charged_tab [NBINS];

  usage_out_t pending_usage_out [$];
  usage_out_t head;
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  logic [TIME_W-1:0] clock_us = '0;

  motor_usage_bin_tracker_core #(.BIN_WIDTH(BWIDTH), .NUM_BINS(NBINS)) uut (.*);

  always #5 clk = ~clk;

  function automatic void charge_bin_time(int idx, logic [TIME_W-1:0] dur);
    logic [TIME_W:0] sum;
    logic [USAGE_W-1:0] fresh;
    logic [USAGE_W-1:0] charged;
    longint tgt;
    longint dlt;
    logic [63:0] mag;
    logic [63:0] step;
    sum = (TIME_W+1)'(usage_tab[idx]) + (TIME_W+1)'(dur);
    fresh = (sum > (TIME_W+1)'(USAGE_MAX)) ? USAGE_MAX : sum[USAGE_W-1:0];
    charged = fresh - usage_tab[idx];
    tgt = longint'(rpm_latched) * 256;
    usage_tab[idx] = fresh;
    if (!charged_tab[idx]) begin
      charged_tab[idx] = 1'b1;
      avg_tab[idx] = 24'(tgt);
    end else if (charged != '0) begin
      dlt = tgt - longint'(avg_tab[idx]);
      mag = (dlt < 0) ? -dlt : dlt;
      step = (mag * 64'(charged)) / 64'(fresh);
      if (dlt < 0) avg_tab[idx] = 24'(longint'(avg_tab[idx]) - longint'(step));
      else avg_tab[idx] = 24'(longint'(avg_tab[idx]) + longint'(step));
    end
  endfunction

  function automatic void track_usage(logic [1:0] act, logic signed [RPM_W-1:0] rpm,
                                      logic [PULSE_W-1:0] pulse, logic [TIME_W-1:0] t);
    usage_out_t r;
    int mag;
    int srpm;
    int nbin;
    logic [TIME_W-1:0] dur;
    logic [TOTAL_W-1:0] total;
    logic stale;
    case (act)
      ACT_RPM: begin
        rpm_latched = rpm;
        rpm_time = t;
      end
      ACT_PULSE: begin
        mag = int'(rpm_latched);
        if (mag < 0) mag = -mag;
        if (mag > 32767) mag = 32767;
        if (last_pulse_ok) begin
          dur = (t >= last_pulse_time) ? t - last_pulse_time : '0;
          if (int'(last_pulse) / BWIDTH < NBINS)
            charge_bin_time(int'(last_pulse) / BWIDTH, dur);
        end
        last_pulse = pulse;
        last_pulse_time = t;
        last_pulse_ok = 1'b1;
        if (pulse > neutral_cfg) srpm = mag;
        else if (pulse < neutral_cfg) srpm = -mag;
        else srpm = 0;
        r = '0;
        r.kind = KIND_STATUS;
        r.signed_rpm = 16'(srpm);
        r.last = 1'b1;
        pending_usage_out.push_back(r);
      end
      ACT_REPORT: begin
        nbin = int'(neutral_cfg) / BWIDTH;
        stale = (t >= rpm_time) && ((t - rpm_time) > TIME_W'(timeout_cfg));
        total = '0;
        for (int k = 0; k < NBINS; k++) begin
          r = '0;
          r.kind = KIND_RECORD;
          r.bin_start = 12'(k * BWIDTH);
          r.bin_used = charged_tab[k];
          r.usage_us = usage_tab[k];
          r.avg_rpm_q8 = avg_tab[k];
          r.rpm_stale = stale;
          if (k != nbin) total += TOTAL_W'(usage_tab[k]);
          if (k == NBINS - 1) begin
            r.total_running_us = total;
            r.last = 1'b1;
          end
          pending_usage_out.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $error("%s: expected %0h, got %0h", field, want, got);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_usage_out.size() == 0) begin
        fail_count++;
        $error("result with no transaction pending");
      end else begin
        head = pending_usage_out.pop_front();
        check_field("kind", 64'(head.kind), 64'(kind));
        check_field("signed_rpm", 64'($unsigned(head.signed_rpm)), 64'($unsigned(signed_rpm)));
        check_field("bin_start", 64'(head.bin_start), 64'(bin_start));
        check_field("bin_used", 64'(head.bin_used), 64'(bin_used));
        check_field("usage_us", 64'(head.usage_us), 64'(usage_us));
        check_field("avg_rpm_q8", 64'($unsigned(head.avg_rpm_q8)), 64'($unsigned(avg_rpm_q8)));
        check_field("total_running_us", 64'(head.total_running_us), 64'(total_running_us));
        check_field("rpm_stale", 64'(head.rpm_stale), 64'(rpm_stale));
        check_field("last", 64'(head.last), 64'(last));
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_transaction(logic [1:0] act, logic signed [RPM_W-1:0] rpm,
                                  logic [PULSE_W-1:0] pulse, logic [TIME_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    rpm_in <= rpm;
    pulse_micros <= pulse;
    now_us <= t;
    do @(posedge clk); while (!in_ready);
    track_usage(act, rpm, pulse, t);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_usage_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_NEUTRAL) neutral_cfg = value[PULSE_W-1:0];
    else timeout_cfg = value;
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_transaction(ACT_REPORT, '0, '0, 48'd0);
    // first pulse transaction only stores width and time
    send_transaction(ACT_PULSE, '0, 12'd0, 48'd1000);
    send_transaction(ACT_RPM, 16'sh8000, '0, 48'd2000);
    // most negative rpm clips to full positive magnitude
    send_transaction(ACT_PULSE, '0, 12'd1600, 48'd5000);
    send_transaction(ACT_PULSE, '0, 12'd1500, 48'd5000);
    send_transaction(ACT_RPM, 16'sh7FFF, '0, 48'd6000);
    send_transaction(ACT_PULSE, '0, 12'd1500, 48'd10000);
    send_transaction(ACT_RPM, 16'sd100, '0, 48'd15000);
    send_transaction(ACT_PULSE, '0, 12'd1499, 48'd20000);
    send_transaction(ACT_PULSE, '0, 12'd4095, 48'd30000);
    // previous width past the table
    send_transaction(ACT_PULSE, '0, 12'd3200, 48'd40000);
    send_transaction(ACT_PULSE, '0, 12'd3199, 48'd50000);
    // time runs backwards
    send_transaction(ACT_PULSE, '0, 12'd100, 48'd45000);
    // usage saturates, then a charge with nothing left to add
    send_transaction(ACT_PULSE, '0, 12'd100, 48'h0200_0000_0000);
    send_transaction(ACT_PULSE, '0, 12'd100, 48'hFFFF_FFFF_FFFF);
    send_transaction(ACT_UNUSED, 16'shFFFF, 12'hFFF, 48'hFFFF_FFFF_FFFF);
    send_transaction(ACT_REPORT, '0, '0, 48'hFFFF_FFFF_FFFF);
    send_transaction(ACT_RPM, -16'sd1, '0, 48'hFFFF_FFFF_FFFF);
    // rpm newer than the request: never stale
    send_transaction(ACT_REPORT, '0, '0, 48'd1000);
    send_transaction(ACT_PULSE, '0, 12'd1500, 48'd2000);
    send_transaction(ACT_REPORT, '0, '0, 48'd3000);
  endtask

  task automatic test_config_sweep();
    logic [PULSE_W-1:0] n;
    logic [TIMEOUT_W-1:0] tmo;
    clock_us = 48'd100;
    for (int s = 0; s < 5; s++) begin
      case (s)
        0: begin n = 12'd0; tmo = 32'd0; end
        1: begin n = 12'd4095; tmo = 32'hFFFF_FFFF; end
        2: begin n = 12'd3199; tmo = 32'd1; end
        3: begin n = 12'd3200; tmo = 32'($urandom_range(20_000_000)); end
        default: begin n = 12'($urandom); tmo = $urandom; end
      endcase
      write_setting(CFG_NEUTRAL, {20'($urandom), n});
      write_setting(CFG_TIMEOUT, tmo);
      clock_us += 48'($urandom_range(1, 400_000));
      send_transaction(ACT_RPM, 16'($urandom), 12'($urandom), clock_us);
      clock_us += 48'($urandom_range(1, 400_000));
      send_transaction(ACT_PULSE, 16'($urandom), n, clock_us);
      clock_us += 48'($urandom_range(1, 400_000));
      send_transaction(ACT_PULSE, 16'($urandom), n + 12'd1, clock_us);
      clock_us += 48'($urandom_range(1, 400_000));
      send_transaction(ACT_PULSE, 16'($urandom), n - 12'd1, clock_us);
      clock_us += 48'($urandom_range(1, 2_000_000));
      send_transaction(ACT_REPORT, 16'($urandom), 12'($urandom), clock_us);
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 400;
    repeat (4) begin
      clock_us += 48'($urandom_range(1, 300_000));
      send_transaction(ACT_PULSE, '0, 12'($urandom_range(3199)), clock_us);
      send_transaction(ACT_REPORT, '0, '0, clock_us);
      send_transaction(ACT_RPM, 16'($urandom), '0, clock_us);
    end
  endtask

  task automatic test_random(int send_pct, int recv_pct, int count,
                             logic [PULSE_W-1:0] neutral, logic [TIMEOUT_W-1:0] tmo);
    int done;
    int pick;
    logic [1:0] act;
    logic [PULSE_W-1:0] pulse;
    write_setting(CFG_NEUTRAL, {20'($urandom), neutral});
    write_setting(CFG_TIMEOUT, tmo);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(199);
      if (pick < 4) clock_us = 48'({$urandom, $urandom});
      else if (pick < 12) clock_us = clock_us - 48'($urandom_range(5000));
      else if (pick < 30) clock_us = clock_us + 48'($urandom_range(40_000_000));
      else clock_us = clock_us + 48'($urandom_range(250_000));
      // favour a few widths so that bin averages keep moving
      pick = $urandom_range(99);
      if (pick < 55) begin
        case ($urandom_range(5))
          0: pulse = neutral_cfg;
          1: pulse = neutral_cfg + 12'd1;
          2: pulse = neutral_cfg - 12'd1;
          3: pulse = 12'd1000;
          4: pulse = 12'd2000;
          default: pulse = 12'd1250;
        endcase
      end else if (pick < 85) begin
        pulse = 12'($urandom_range(3199));
      end else begin
        pulse = 12'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 30) act = ACT_RPM;
      else if (pick < 75) act = ACT_PULSE;
      else if (pick < 93) act = ACT_REPORT;
      else act = ACT_UNUSED;
      send_transaction(act, 16'($urandom), pulse, clock_us);
      if (act != ACT_UNUSED) done++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random(16, 85, 62, 12'd1500, 32'd10_000_000);
    test_random(85, 16, 62, 12'($urandom_range(3199)), 32'($urandom_range(40_000_000)));
    test_random(0, 0, 62, NEUTRAL_RESET, TIMEOUT_RESET);
    settle();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
